/* rtl/core/npc_pkg.sv */
// Shared types and constants for the nearest palette color matcher.
`default_nettype none
package npc_pkg;

  localparam int ENTRIES   = 256;               // palette depth, 2..256
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int COMP_W    = 8;                 // stored color component
  localparam int QCOMP_W   = 6;                 // query color component
  localparam int RGB_W     = 3 * COMP_W;
  localparam int QRGB_W    = 3 * QCOMP_W;
  localparam int SQ_W      = 2 * COMP_W;
  localparam int DIST_W    = 22;                // wide enough for the start value
  localparam logic [DIST_W-1:0] START_MIN = 22'h300000;
  localparam int IDX_W     = 8;                 // index fields on the ports
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // One decoded operation, as handed from front end to scan engine.
  typedef struct packed {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   addr;
    logic [RGB_W-1:0]    rgb;   // {red, green, blue}
    logic [QRGB_W-1:0]   qrgb;  // {red, green, blue}
  } op_t;

endpackage
`default_nettype wire

/* rtl/core/npc_front.sv */
// Front end: unpacks input transfers, drops out-of-range writes, feeds the queue.
`default_nettype none
module npc_front (
  input  wire logic                           tvalid,
  output logic                                tready,
  input  wire logic [npc_pkg::S_TDATA_W-1:0]  tdata,
  input  wire logic                           tuser,
  input  wire logic                           q_ready,
  output logic                                push,
  output npc_pkg::op_t                        op
);

  logic [npc_pkg::IDX_W-1:0] entry_index;
  logic                      keep;

  assign entry_index = tdata[7:0];

  always_comb begin
    op.cmd  = npc_pkg::cmd_t'(tuser);
    op.addr = entry_index[npc_pkg::ADDR_W-1:0];
    // stored as {red, green, blue}
    op.rgb  = {tdata[15:8], tdata[23:16], tdata[31:24]};
    op.qrgb = {tdata[37:32], tdata[43:38], tdata[49:44]};
  end

  // writes past the palette end are taken and dropped
  assign keep   = (op.cmd == npc_pkg::CMD_QUERY) ||
                  (int'(entry_index) < npc_pkg::ENTRIES);
  assign tready = q_ready;
  assign push   = tvalid && q_ready && keep;

endmodule
`default_nettype wire

/* rtl/core/npc_queue.sv */
// Short FIFO of decoded operations between front end and scan engine.
`default_nettype none
module npc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire npc_pkg::op_t  push_op,
  output logic               push_ready,
  output logic               pop_valid,
  output npc_pkg::op_t       pop_op,
  input  wire logic          pop
);

  npc_pkg::op_t                  slots [npc_pkg::QUEUE_DEPTH];
  logic [npc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [npc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [npc_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (int'(count) < npc_pkg::QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == npc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == npc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/npc_back.sv */
// Scan engine: palette memory, distance pipeline, running minimum, result register.
`default_nettype none
module npc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire npc_pkg::op_t                  q_op,
  output logic                               q_pop,
  output logic                               tvalid,
  input  wire logic                          tready,
  output logic [npc_pkg::M_TDATA_W-1:0]      tdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [npc_pkg::ADDR_W-1:0] LAST_ADDR = npc_pkg::ADDR_W'(npc_pkg::ENTRIES - 1);

  state_t                          state;
  logic [npc_pkg::RGB_W-1:0]       palette [npc_pkg::ENTRIES];
  logic [npc_pkg::ADDR_W-1:0]      scan_addr;
  logic [npc_pkg::COMP_W-1:0]      q_red, q_green, q_blue;

  // stage 1: memory read
  logic                            rd_valid, rd_last;
  logic [npc_pkg::ADDR_W-1:0]      rd_idx;
  logic [npc_pkg::RGB_W-1:0]       rd_data;
  // stage 2: squared differences
  logic                            sq_valid, sq_last;
  logic [npc_pkg::ADDR_W-1:0]      sq_idx;
  logic [npc_pkg::SQ_W-1:0]        sq_r, sq_g, sq_b;

  logic [npc_pkg::COMP_W-1:0]      ad_r, ad_g, ad_b;
  logic [npc_pkg::DIST_W-1:0]      cand_dist;
  logic                            better;
  logic [npc_pkg::DIST_W-1:0]      best_dist;
  logic [npc_pkg::ADDR_W-1:0]      best_idx;
  logic                            mem_we;

  function automatic logic [npc_pkg::COMP_W-1:0] abs_diff(
    input logic [npc_pkg::COMP_W-1:0] a,
    input logic [npc_pkg::COMP_W-1:0] b
  );
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign mem_we = q_pop && (q_op.cmd == npc_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette[q_op.addr] <= q_op.rgb;
    end
    rd_data <= palette[scan_addr];
  end

  always_comb begin
    ad_r = abs_diff(rd_data[23:16], q_red);
    ad_g = abs_diff(rd_data[15:8],  q_green);
    ad_b = abs_diff(rd_data[7:0],   q_blue);
    cand_dist = npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);
    better = sq_valid && (cand_dist < best_dist);   // strict: lower index keeps ties
  end

  always_ff @(posedge clk) begin
    sq_r   <= ad_r * ad_r;
    sq_g   <= ad_g * ad_g;
    sq_b   <= ad_b * ad_b;
    rd_idx <= scan_addr;
    sq_idx <= rd_idx;
    if (q_pop && q_op.cmd == npc_pkg::CMD_QUERY) begin
      q_red   <= {2'b00, q_op.qrgb[17:12]};
      q_green <= {2'b00, q_op.qrgb[11:6]};
      q_blue  <= {2'b00, q_op.qrgb[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      rd_last   <= 1'b0;
      sq_valid  <= 1'b0;
      sq_last   <= 1'b0;
      best_dist <= npc_pkg::START_MIN;
      best_idx  <= '0;
      tvalid    <= 1'b0;
      tdata     <= '0;
    end else begin
      rd_valid <= (state == S_SCAN);
      rd_last  <= (state == S_SCAN) && (scan_addr == LAST_ADDR);
      sq_valid <= rd_valid;
      sq_last  <= rd_last;
      // result register: load when free or being taken, else clear on transfer
      if (state == S_DONE && (!tvalid || tready)) begin
        tvalid <= 1'b1;
        tdata  <= npc_pkg::M_TDATA_W'(best_idx);
      end else if (tvalid && tready) begin
        tvalid <= 1'b0;
      end
      if (better) begin
        best_dist <= cand_dist;
        best_idx  <= sq_idx;
      end
      unique case (state)
        S_IDLE: begin
          scan_addr <= '0;
          if (q_pop && q_op.cmd == npc_pkg::CMD_QUERY) begin
            best_dist <= npc_pkg::START_MIN;
            best_idx  <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (sq_valid && sq_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!tvalid || tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/nearest_palette_color.sv */
// Top level of the nearest palette color matcher.
//
// Input stream (s_axis_*): one transfer per operation. tuser selects the kind:
//   0 writes palette entry entry_index with {red, green, blue}, no result;
//   1 queries the 6-bit color and yields one result transfer.
// Output stream (m_axis_*): tdata carries the index of the palette entry with
//   the smallest squared Euclidean distance; the lowest index wins ties.
// A two-deep queue decouples the input side from the scan engine, so input
//   transfers keep being taken while a scan runs or a result waits, until the queue is full.
// A write is taken from the queue and stored while the scan engine stays idle.
//   A query occupies it while one palette entry is read per cycle from the
//   palette memory, and then while the two-stage distance pipeline drains.
// All entries must be written before the first query; the palette memory is
//   not cleared by reset. Reset empties the queue and the output register.
// When the receiver stalls, the finished result holds in the output register;
//   the next query runs its scan and then waits until that register frees.
`default_nettype none
module nearest_palette_color (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: entry_index[7:0], entry_red[15:8], entry_green[23:16],
  //   entry_blue[31:24], query_red[37:32], query_green[43:38],
  //   query_blue[49:44], zero fill[55:50]
  input  wire logic [npc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: command (0 write, 1 query)
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: nearest_index[7:0]
  output logic [npc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  logic          push;
  logic          push_ready;
  npc_pkg::op_t  push_op;
  logic          q_valid;
  logic          q_pop;
  npc_pkg::op_t  q_op;

  npc_front u_front (
    .tvalid  (s_axis_tvalid),
    .tready  (s_axis_tready),
    .tdata   (s_axis_tdata),
    .tuser   (s_axis_tuser),
    .q_ready (push_ready),
    .push    (push),
    .op      (push_op)
  );

  npc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_op     (q_op),
    .pop        (q_pop)
  );

  npc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .tvalid  (m_axis_tvalid),
    .tready  (m_axis_tready),
    .tdata   (m_axis_tdata)
  );

endmodule
`default_nettype wire
